### design/bilinear_table_interpolator_assert.svh
// Assertion macros for the bilinear table interpolator checker.
// Needs a clk and rst in the scope that uses them.
`ifndef BILINEAR_TABLE_INTERPOLATOR_ASSERT_SVH
`define BILINEAR_TABLE_INTERPOLATOR_ASSERT_SVH
// same-cycle implication
`define BTI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bti assertion failed");
// next-cycle implication
`define BTI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bti assertion failed");
`endif

### design/bti_pkg.sv
// Shared constants, codes and controller/datapath types for the
// bilinear table interpolator. No dependencies.
package bti_pkg;
  localparam int VALUE_BITS  = 32;
  localparam int MAX_X_KNOTS = 16;
  localparam int MAX_Y_KNOTS = 16;
  localparam int GRID_DEPTH  = 256;
  localparam int KNOT_AW     = 4;
  localparam int GRID_AW     = 8;
  localparam int CNT_BITS    = 5;
  localparam int W_BITS      = 33;
  localparam int MPL_BITS    = 34;
  localparam int AREA_BITS   = 66;
  localparam int ACC_BITS    = 100;
  localparam int DIVN_BITS   = 99;
  localparam int Q_BITS      = 33;
  localparam int STEP_BITS   = 7;
  localparam int SEARCH_LAST = 14;
  localparam int MUL_STEPS   = 34;
  localparam int DIV_STEPS   = 99;

  localparam logic [1:0] ACT_LOAD_X = 2'd0;
  localparam logic [1:0] ACT_LOAD_Y = 2'd1;
  localparam logic [1:0] ACT_LOAD_G = 2'd2;
  localparam logic [1:0] ACT_QUERY  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_EXTR = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;
  localparam logic [1:0] ST_SAT  = 2'd3;

  localparam logic REG_X_COUNT = 1'b0;
  localparam logic REG_Y_COUNT = 1'b1;

  localparam logic [4:0] OP_IDLE      = 5'd0;
  localparam logic [4:0] OP_LOAD      = 5'd1;
  localparam logic [4:0] OP_START     = 5'd2;
  localparam logic [4:0] OP_SRCH      = 5'd3;
  localparam logic [4:0] OP_EDGE_LO   = 5'd4;
  localparam logic [4:0] OP_EDGE_HI   = 5'd5;
  localparam logic [4:0] OP_FETCH_LO  = 5'd6;
  localparam logic [4:0] OP_FETCH_HI  = 5'd7;
  localparam logic [4:0] OP_WEIGHTS   = 5'd8;
  localparam logic [4:0] OP_AREA_INIT = 5'd9;
  localparam logic [4:0] OP_MUL_STEP  = 5'd10;
  localparam logic [4:0] OP_AREA_DONE = 5'd11;
  localparam logic [4:0] OP_WMUL_INIT = 5'd12;
  localparam logic [4:0] OP_WMUL_DONE = 5'd13;
  localparam logic [4:0] OP_GMUL_INIT = 5'd14;
  localparam logic [4:0] OP_GMUL_DONE = 5'd15;
  localparam logic [4:0] OP_DIV_INIT  = 5'd16;
  localparam logic [4:0] OP_DIV_STEP  = 5'd17;
  localparam logic [4:0] OP_EMIT      = 5'd18;
  localparam logic [4:0] OP_EMIT_ZERO = 5'd19;

  typedef struct packed {
    logic [4:0]           op;
    logic [1:0]           corner;
    logic [STEP_BITS-1:0] step;
  } bti_cmd_t;

  typedef struct packed {
    logic area_zero;
  } bti_stat_t;
endpackage

### design/bti_if.sv
// Valid/ready channel interfaces for input and result words.
// Depends on nothing.
interface bti_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [7:0]         entry_index;
  logic signed [31:0] entry_value;
  logic signed [31:0] query_x;
  logic signed [31:0] query_y;
  modport source (output valid, action, entry_index, entry_value, query_x, query_y,
                  input ready);
  modport sink (input valid, action, entry_index, entry_value, query_x, query_y,
                output ready);
endinterface

interface bti_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] interp_value;
  logic [1:0]         status;
  modport source (output valid, interp_value, status, input ready);
  modport sink (input valid, interp_value, status, output ready);
endinterface

### design/bti_ctrl.sv
// Controller state machine: takes loads, sequences search, multiplies, divide and emit.
// Depends on bti_pkg.
module bti_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          in_action,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  bti_pkg::bti_stat_t  stat,
  output bti_pkg::bti_cmd_t   cmd
);
  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_SRCH      = 5'd1;
  localparam logic [4:0] S_EDGE_LO   = 5'd2;
  localparam logic [4:0] S_EDGE_HI   = 5'd3;
  localparam logic [4:0] S_FETCH_LO  = 5'd4;
  localparam logic [4:0] S_FETCH_HI  = 5'd5;
  localparam logic [4:0] S_WEIGHTS   = 5'd6;
  localparam logic [4:0] S_AREA_INIT = 5'd7;
  localparam logic [4:0] S_AREA_MUL  = 5'd8;
  localparam logic [4:0] S_AREA_DONE = 5'd9;
  localparam logic [4:0] S_AREA_CHK  = 5'd10;
  localparam logic [4:0] S_WMUL_INIT = 5'd11;
  localparam logic [4:0] S_WMUL      = 5'd12;
  localparam logic [4:0] S_WMUL_DONE = 5'd13;
  localparam logic [4:0] S_GMUL_INIT = 5'd14;
  localparam logic [4:0] S_GMUL      = 5'd15;
  localparam logic [4:0] S_GMUL_DONE = 5'd16;
  localparam logic [4:0] S_DIV_INIT  = 5'd17;
  localparam logic [4:0] S_DIV       = 5'd18;
  localparam logic [4:0] S_EMIT      = 5'd19;

  localparam logic [bti_pkg::STEP_BITS-1:0] SRCH_END =
    bti_pkg::STEP_BITS'(bti_pkg::SEARCH_LAST);
  localparam logic [bti_pkg::STEP_BITS-1:0] MUL_END =
    bti_pkg::STEP_BITS'(bti_pkg::MUL_STEPS - 1);
  localparam logic [bti_pkg::STEP_BITS-1:0] DIV_END =
    bti_pkg::STEP_BITS'(bti_pkg::DIV_STEPS - 1);

  logic [4:0]                      state, state_next;
  logic [bti_pkg::STEP_BITS-1:0]   cnt, cnt_next;
  logic [1:0]                      corner, corner_next;
  logic                            zero_res, zero_res_next;
  logic                            out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    corner_next    = corner;
    zero_res_next  = zero_res;
    out_valid_next = out_valid && !out_ready;
    cmd.op         = bti_pkg::OP_IDLE;
    cmd.corner     = corner;
    cmd.step       = cnt;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == bti_pkg::ACT_QUERY) begin
            cmd.op     = bti_pkg::OP_START;
            cnt_next   = bti_pkg::STEP_BITS'(1);
            state_next = S_SRCH;
          end else begin
            cmd.op = bti_pkg::OP_LOAD;
          end
        end
      end
      S_SRCH: begin
        cmd.op = bti_pkg::OP_SRCH;
        if (cnt == SRCH_END) begin
          state_next = S_EDGE_LO;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_EDGE_LO: begin
        cmd.op     = bti_pkg::OP_EDGE_LO;
        state_next = S_EDGE_HI;
      end
      S_EDGE_HI: begin
        cmd.op     = bti_pkg::OP_EDGE_HI;
        state_next = S_FETCH_LO;
      end
      S_FETCH_LO: begin
        cmd.op     = bti_pkg::OP_FETCH_LO;
        state_next = S_FETCH_HI;
      end
      S_FETCH_HI: begin
        cmd.op     = bti_pkg::OP_FETCH_HI;
        state_next = S_WEIGHTS;
      end
      S_WEIGHTS: begin
        cmd.op     = bti_pkg::OP_WEIGHTS;
        state_next = S_AREA_INIT;
      end
      S_AREA_INIT: begin
        cmd.op     = bti_pkg::OP_AREA_INIT;
        cnt_next   = '0;
        state_next = S_AREA_MUL;
      end
      S_AREA_MUL: begin
        cmd.op = bti_pkg::OP_MUL_STEP;
        if (cnt == MUL_END) begin
          state_next = S_AREA_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_AREA_DONE: begin
        cmd.op     = bti_pkg::OP_AREA_DONE;
        state_next = S_AREA_CHK;
      end
      S_AREA_CHK: begin
        corner_next = 2'd0;
        if (stat.area_zero) begin
          zero_res_next = 1'b1;
          state_next    = S_EMIT;
        end else begin
          zero_res_next = 1'b0;
          state_next    = S_WMUL_INIT;
        end
      end
      S_WMUL_INIT: begin
        cmd.op     = bti_pkg::OP_WMUL_INIT;
        cnt_next   = '0;
        state_next = S_WMUL;
      end
      S_WMUL: begin
        cmd.op = bti_pkg::OP_MUL_STEP;
        if (cnt == MUL_END) begin
          state_next = S_WMUL_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_WMUL_DONE: begin
        cmd.op     = bti_pkg::OP_WMUL_DONE;
        state_next = S_GMUL_INIT;
      end
      S_GMUL_INIT: begin
        cmd.op     = bti_pkg::OP_GMUL_INIT;
        cnt_next   = '0;
        state_next = S_GMUL;
      end
      S_GMUL: begin
        cmd.op = bti_pkg::OP_MUL_STEP;
        if (cnt == MUL_END) begin
          state_next = S_GMUL_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_GMUL_DONE: begin
        cmd.op = bti_pkg::OP_GMUL_DONE;
        if (corner == 2'd3) begin
          state_next = S_DIV_INIT;
        end else begin
          corner_next = corner + 1'b1;
          state_next  = S_WMUL_INIT;
        end
      end
      S_DIV_INIT: begin
        cmd.op     = bti_pkg::OP_DIV_INIT;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = bti_pkg::OP_DIV_STEP;
        if (cnt == DIV_END) begin
          state_next = S_EMIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.op         = zero_res ? bti_pkg::OP_EMIT_ZERO : bti_pkg::OP_EMIT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      corner    <= 2'd0;
      zero_res  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      corner    <= corner_next;
      zero_res  <= zero_res_next;
      out_valid <= out_valid_next;
    end
  end
endmodule

### design/bti_datapath.sv
// Datapath: knot and grid storage, bracket search, serial multiplier,
// restoring divider and result register. Depends on bti_pkg.
module bti_datapath (
  input  logic               clk,
  input  logic               rst,
  input  bti_pkg::bti_cmd_t  cmd,
  output bti_pkg::bti_stat_t stat,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [4:0]         cfg_data,
  input  logic [1:0]         action,
  input  logic [7:0]         entry_index,
  input  logic signed [31:0] entry_value,
  input  logic signed [31:0] query_x,
  input  logic signed [31:0] query_y,
  output logic signed [31:0] interp_value,
  output logic [1:0]         status
);
  localparam int VB = bti_pkg::VALUE_BITS;
  localparam int KA = bti_pkg::KNOT_AW;
  localparam int CB = bti_pkg::CNT_BITS;
  localparam int WB = bti_pkg::W_BITS;
  localparam int MB = bti_pkg::MPL_BITS;
  localparam int AB = bti_pkg::AREA_BITS;
  localparam int NB = bti_pkg::ACC_BITS;
  localparam int DB = bti_pkg::DIVN_BITS;
  localparam int QB = bti_pkg::Q_BITS;
  localparam int GA = bti_pkg::GRID_AW;
  localparam logic [QB-1:0] LIM = QB'(1) << (VB - 1);

  logic signed [VB-1:0] ax [bti_pkg::MAX_X_KNOTS];
  logic signed [VB-1:0] ay [bti_pkg::MAX_Y_KNOTS];
  logic signed [VB-1:0] grid [bti_pkg::GRID_DEPTH];
  logic [CB-1:0]        x_count, y_count, nx, ny;
  logic signed [VB-1:0] qx, qy, x1, x2, y1, y2, gq;
  logic [KA-1:0]        ix, iy, k;
  logic                 outside, neg, ovf, last, dbit;
  logic [GA-1:0]        cbase, gaddr;
  logic signed [WB-1:0] wx1, wx2, wy1, wy2, dx, dy, wxs, wys;
  logic signed [AB-1:0] area, wprod;
  logic signed [NB-1:0] acc, mcand, num, absn;
  logic [MB-1:0]        mplier;
  logic [AB-1:0]        absa, dsr, rem;
  logic [AB:0]          r2;
  logic [DB-1:0]        nsh;
  logic [QB-1:0]        quo;
  logic                 sat;

  assign nx = (x_count < CB'(2)) ? CB'(2) :
              (x_count > CB'(bti_pkg::MAX_X_KNOTS)) ? CB'(bti_pkg::MAX_X_KNOTS) : x_count;
  assign ny = (y_count < CB'(2)) ? CB'(2) :
              (y_count > CB'(bti_pkg::MAX_Y_KNOTS)) ? CB'(bti_pkg::MAX_Y_KNOTS) : y_count;
  assign k    = cmd.step[KA-1:0];
  assign last = (cmd.step == bti_pkg::STEP_BITS'(bti_pkg::MUL_STEPS - 1));
  assign wxs  = cmd.corner[0] ? wx1 : wx2;
  assign wys  = cmd.corner[1] ? wy1 : wy2;
  assign gaddr = cbase + (cmd.corner[0] ? GA'(1) : GA'(0))
                       + (cmd.corner[1] ? GA'(nx) : GA'(0));
  assign absn = num[NB-1] ? -num : num;
  assign absa = area[AB-1] ? AB'(-area) : AB'(area);
  assign r2   = {rem, nsh[DB-1]};
  assign dbit = (r2 >= {1'b0, dsr});
  assign sat  = ovf || (neg ? (quo > LIM) : (quo >= LIM));
  assign stat.area_zero = (area == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      x_count <= CB'(16);
      y_count <= CB'(16);
    end else if (cfg_we) begin
      if (cfg_index == bti_pkg::REG_X_COUNT) begin
        x_count <= cfg_data;
      end else begin
        y_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == bti_pkg::OP_LOAD && action == bti_pkg::ACT_LOAD_G) begin
      grid[entry_index] <= entry_value;
    end
    if (cmd.op == bti_pkg::OP_WMUL_INIT) begin
      gq <= grid[gaddr];
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      bti_pkg::OP_LOAD: begin
        if (entry_index < 8'(bti_pkg::MAX_X_KNOTS) && action == bti_pkg::ACT_LOAD_X) begin
          ax[entry_index[KA-1:0]] <= entry_value;
        end
        if (entry_index < 8'(bti_pkg::MAX_Y_KNOTS) && action == bti_pkg::ACT_LOAD_Y) begin
          ay[entry_index[KA-1:0]] <= entry_value;
        end
      end
      bti_pkg::OP_START: begin
        qx      <= query_x;
        qy      <= query_y;
        ix      <= '0;
        iy      <= '0;
        outside <= 1'b0;
      end
      bti_pkg::OP_SRCH: begin
        if ((CB'(k) + CB'(1)) < nx && ax[k] <= qx) begin
          ix <= k;
        end
        if ((CB'(k) + CB'(1)) < ny && ay[k] <= qy) begin
          iy <= k;
        end
      end
      bti_pkg::OP_EDGE_LO: begin
        outside <= outside || (qx < ax[0]) || (qy < ay[0]);
      end
      bti_pkg::OP_EDGE_HI: begin
        outside <= outside || (qx > ax[KA'(nx - CB'(1))]) || (qy > ay[KA'(ny - CB'(1))]);
      end
      bti_pkg::OP_FETCH_LO: begin
        x1    <= ax[ix];
        y1    <= ay[iy];
        cbase <= GA'(ix) + GA'(iy) * GA'(nx);
      end
      bti_pkg::OP_FETCH_HI: begin
        x2 <= ax[KA'(ix + 1'b1)];
        y2 <= ay[KA'(iy + 1'b1)];
      end
      bti_pkg::OP_WEIGHTS: begin
        wx1 <= WB'(qx) - WB'(x1);
        wx2 <= WB'(x2) - WB'(qx);
        wy1 <= WB'(qy) - WB'(y1);
        wy2 <= WB'(y2) - WB'(qy);
        dx  <= WB'(x2) - WB'(x1);
        dy  <= WB'(y2) - WB'(y1);
      end
      bti_pkg::OP_AREA_INIT: begin
        mcand  <= NB'(dx);
        mplier <= MB'(dy);
        acc    <= '0;
      end
      bti_pkg::OP_MUL_STEP: begin
        if (mplier[0]) begin
          acc <= last ? acc - mcand : acc + mcand;
        end
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
      end
      bti_pkg::OP_AREA_DONE: begin
        area <= acc[AB-1:0];
      end
      bti_pkg::OP_WMUL_INIT: begin
        mcand  <= NB'(wxs);
        mplier <= MB'(wys);
        acc    <= '0;
      end
      bti_pkg::OP_WMUL_DONE: begin
        wprod <= acc[AB-1:0];
      end
      bti_pkg::OP_GMUL_INIT: begin
        mcand  <= NB'(wprod);
        mplier <= MB'(gq);
        acc    <= (cmd.corner == 2'd0) ? '0 : num;
      end
      bti_pkg::OP_GMUL_DONE: begin
        num <= acc;
      end
      bti_pkg::OP_DIV_INIT: begin
        nsh <= DB'((absn <<< 1) + NB'(absa));
        dsr <= absa << 1;
        rem <= '0;
        quo <= '0;
        ovf <= 1'b0;
        neg <= num[NB-1] ^ area[AB-1];
      end
      bti_pkg::OP_DIV_STEP: begin
        rem <= dbit ? AB'(r2 - {1'b0, dsr}) : AB'(r2);
        nsh <= nsh << 1;
        quo <= {quo[QB-2:0], dbit};
        ovf <= ovf | quo[QB-1];
      end
      bti_pkg::OP_EMIT: begin
        if (sat) begin
          interp_value <= neg ? VB'(LIM) : VB'(LIM - QB'(1));
          status       <= bti_pkg::ST_SAT;
        end else begin
          interp_value <= neg ? -quo[VB-1:0] : quo[VB-1:0];
          status       <= outside ? bti_pkg::ST_EXTR : bti_pkg::ST_OK;
        end
      end
      bti_pkg::OP_EMIT_ZERO: begin
        interp_value <= '0;
        status       <= bti_pkg::ST_ZERO;
      end
      default: begin
      end
    endcase
  end
endmodule

### design/bilinear_table_interpolator.sv
// Channel  Dir  Handshake     Payload
// in_ch    in   valid/ready   action, entry_index, entry_value, query_x, query_y
// out_ch   out  valid/ready   interp_value, status
// cfg      in   cfg_we        cfg_index (0 x_count, 1 y_count), cfg_data
// A load is taken while idle and leaves input ready high. A query goes from
// accept to result word through 14 search steps, five 34-step serial multiplies
// plus four grid multiplies, and a 99-step restoring divide (a zero-area cell
// skips from the area to the result). Input ready is low while a query runs.
// Reset (rst, synchronous) clears control and sets both counts to 16.
// A result held by a stalled output blocks only the emit of the next query.
// Top level of the bilinear table interpolator; uses bti_pkg, the channel
// interfaces, bti_ctrl and bti_datapath.
module bilinear_table_interpolator (
  input  logic        clk,
  input  logic        rst,
  bti_in_if.sink      in_ch,
  bti_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);
  bti_pkg::bti_cmd_t  cmd;
  bti_pkg::bti_stat_t stat;
  logic               in_ready, out_valid;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  bti_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bti_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .action       (in_ch.action),
    .entry_index  (in_ch.entry_index),
    .entry_value  (in_ch.entry_value),
    .query_x      (in_ch.query_x),
    .query_y      (in_ch.query_y),
    .interp_value (out_ch.interp_value),
    .status       (out_ch.status)
  );
endmodule

### design/bti_checker.sv
// Port-level checker for the bilinear table interpolator and its bind.
// Depends on bti_pkg and bilinear_table_interpolator_assert.svh.
`include "bilinear_table_interpolator_assert.svh"
module bti_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value,
  input logic [1:0]  out_status
);
  logic zero_word, sat_word, sat_bound, query_acc;

  assign zero_word = out_valid && out_status == bti_pkg::ST_ZERO;
  assign sat_word  = out_valid && out_status == bti_pkg::ST_SAT;
  assign sat_bound = out_value == 32'h7fffffff || out_value == 32'h80000000;
  assign query_acc = in_valid && in_ready && in_action == bti_pkg::ACT_QUERY;

  `BTI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `BTI_ASSERT_NOW(a_zero_val, zero_word, out_value == 32'd0)
  `BTI_ASSERT_NOW(a_sat_val, sat_word, sat_bound)
  `BTI_ASSERT_NEXT(a_query_busy, query_acc, !in_ready)
endmodule

bind bilinear_table_interpolator bti_checker u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_action  (in_ch.action),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_value  (out_ch.interp_value),
  .out_status (out_ch.status)
);

### test/bti_scoreboard.sv
`timescale 1ns / 1ps
// Checker for the bilinear table interpolator: watches the input, result and
// register ports, predicts each query word and compares. Uses bti_pkg, bti_if.
module bti_scoreboard (
  input  logic       clk,
  input  logic       rst,
  bti_in_if          in_ch,
  bti_out_if         out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data,
  output int         errors,
  output int         pending
);

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } interp_result_t;

  logic signed [31:0] x_knots [bti_pkg::MAX_X_KNOTS];
  logic signed [31:0] y_knots [bti_pkg::MAX_Y_KNOTS];
  logic signed [31:0] grid    [bti_pkg::GRID_DEPTH];
  logic [4:0]         x_count, y_count;
  interp_result_t     expected_q [$];

  function automatic interp_result_t predict_interp(logic signed [31:0] qx,
                                                    logic signed [31:0] qy);
    int nx, ny, ix, iy, c, k;
    logic outside, neg;
    logic signed [127:0] px, py, x1, x2, y1, y2, wx1, wx2, wy1, wy2;
    logic signed [127:0] g0, g1, g2, g3, area, num, mag_n, mag_a, m, lim;
    interp_result_t r;
    nx = (x_count < 2) ? 2 : (x_count > bti_pkg::MAX_X_KNOTS) ? bti_pkg::MAX_X_KNOTS :
         int'(x_count);
    ny = (y_count < 2) ? 2 : (y_count > bti_pkg::MAX_Y_KNOTS) ? bti_pkg::MAX_Y_KNOTS :
         int'(y_count);
    ix = 0;
    for (k = 1; k + 1 < nx; k++) if (x_knots[k] <= qx) ix = k;
    iy = 0;
    for (k = 1; k + 1 < ny; k++) if (y_knots[k] <= qy) iy = k;
    outside = (qx < x_knots[0]) || (qx > x_knots[nx-1]) ||
              (qy < y_knots[0]) || (qy > y_knots[ny-1]);
    px = qx; py = qy;
    x1 = x_knots[ix]; x2 = x_knots[ix+1];
    y1 = y_knots[iy]; y2 = y_knots[iy+1];
    wx2 = x2 - px; wx1 = px - x1;
    wy2 = y2 - py; wy1 = py - y1;
    area = (x2 - x1) * (y2 - y1);
    if (area == 0) begin
      r.value = '0;
      r.status = bti_pkg::ST_ZERO;
      return r;
    end
    c = ix + iy * nx;
    g0 = grid[c]; g1 = grid[c+1]; g2 = grid[c+nx]; g3 = grid[c+nx+1];
    num = g0 * (wx2 * wy2) + g1 * (wx1 * wy2) + g2 * (wx2 * wy1) + g3 * (wx1 * wy1);
    neg = num[127] != area[127];
    mag_n = num[127] ? -num : num;
    mag_a = area[127] ? -area : area;
    m = (2 * mag_n + mag_a) / (2 * mag_a);
    lim = 128'sd1 <<< 31;
    r.status = outside ? bti_pkg::ST_EXTR : bti_pkg::ST_OK;
    if (neg && m > lim) begin
      m = lim;
      r.status = bti_pkg::ST_SAT;
    end else if (!neg && m >= lim) begin
      m = lim - 1;
      r.status = bti_pkg::ST_SAT;
    end
    if (neg) m = -m;
    r.value = m[31:0];
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    interp_result_t exp_r;
    if (rst) begin
      x_count <= 5'd16;
      y_count <= 5'd16;
      expected_q.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == bti_pkg::REG_X_COUNT) x_count <= cfg_data;
        else y_count <= cfg_data;
      end
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.action)
          bti_pkg::ACT_LOAD_X: if (in_ch.entry_index < bti_pkg::MAX_X_KNOTS)
                                 x_knots[in_ch.entry_index] = in_ch.entry_value;
          bti_pkg::ACT_LOAD_Y: if (in_ch.entry_index < bti_pkg::MAX_Y_KNOTS)
                                 y_knots[in_ch.entry_index] = in_ch.entry_value;
          bti_pkg::ACT_LOAD_G: grid[in_ch.entry_index] = in_ch.entry_value;
          default: expected_q.push_back(predict_interp(in_ch.query_x, in_ch.query_y));
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word value=%h status=%0d", $time,
                   out_ch.interp_value, out_ch.status);
          errors <= errors + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.value !== out_ch.interp_value || exp_r.status !== out_ch.status) begin
            $display("%0t: mismatch expected value=%h status=%0d actual value=%h status=%0d",
                     $time, exp_r.value, exp_r.status, out_ch.interp_value, out_ch.status);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

### test/tb_bilinear_table_interpolator.sv
`timescale 1ns / 1ps
// Top of the bilinear table interpolator bench: clock, reset, register phases,
// directed and random words with random idling. Uses bti_pkg, bti_if, bti_scoreboard.
module tb_bilinear_table_interpolator;

  localparam int IDLE_LIMIT = 6000;
  localparam int DRAIN_CYCLES = 500;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we;
  logic       cfg_index;
  logic [4:0] cfg_data;
  logic       quiet = 1'b0;
  int         errors, pending, idle_cycles, stall_left;
  int         nx_use, ny_use;

  logic signed [31:0] x_tab [bti_pkg::MAX_X_KNOTS];
  logic signed [31:0] y_tab [bti_pkg::MAX_Y_KNOTS];

  bti_in_if  in_ch ();
  bti_out_if out_ch ();

  bilinear_table_interpolator uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bti_scoreboard chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always #10 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 100);
  endfunction

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return $urandom_range(0, 255) - 128;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left <= gap_len();
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (!rst && idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send(logic [1:0] act, logic [7:0] idx, logic signed [31:0] val,
                      logic signed [31:0] qx, logic signed [31:0] qy);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.entry_index <= idx;
    in_ch.entry_value <= val;
    in_ch.query_x <= qx;
    in_ch.query_y <= qy;
    if (act == bti_pkg::ACT_LOAD_X && idx < bti_pkg::MAX_X_KNOTS) x_tab[idx] = val;
    if (act == bti_pkg::ACT_LOAD_Y && idx < bti_pkg::MAX_Y_KNOTS) y_tab[idx] = val;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic load(logic [1:0] act, logic [7:0] idx, logic signed [31:0] val);
    send(act, idx, val, rand_word(), rand_word());
  endtask

  task automatic query(logic signed [31:0] qx, logic signed [31:0] qy);
    send(bti_pkg::ACT_QUERY, 8'($urandom), $urandom, qx, qy);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_counts(logic [4:0] xc, logic [4:0] yc);
    cfg_we <= 1'b1; cfg_index <= bti_pkg::REG_X_COUNT; cfg_data <= xc;
    @(posedge clk);
    cfg_index <= bti_pkg::REG_Y_COUNT; cfg_data <= yc;
    @(posedge clk);
    cfg_we <= 1'b0;
    nx_use = (xc < 2) ? 2 : (xc > 16) ? 16 : int'(xc);
    ny_use = (yc < 2) ? 2 : (yc > 16) ? 16 : int'(yc);
  endtask

  task automatic load_axis(logic [1:0] act);
    int mode, i;
    longint v, step;
    mode = $urandom_range(0, 9);
    v = (mode < 4) ? -longint'($urandom_range(0, 1 << 30))
                   : longint'($urandom_range(0, 1 << 20)) - (1 << 19);
    for (i = 0; i < 16; i++) begin
      if (mode == 9) load(act, 8'(i), $urandom);
      else begin
        load(act, 8'(i), v[31:0]);
        step = (mode < 4) ? longint'($urandom_range(1, 1 << 26))
                          : longint'($urandom_range(1, 1 << 18));
        if (mode == 8 && $urandom_range(0, 3) == 0) step = 0;
        v += step;
      end
    end
  endtask

  function automatic logic signed [31:0] pick_coord(logic signed [31:0] tab [16], int n);
    longint lo, hi, v;
    lo = tab[0];
    hi = tab[n-1];
    case ($urandom_range(0, 9))
      0:       v = tab[$urandom_range(0, n-1)];
      1:       v = lo - $urandom_range(1, 1 << 20);
      2:       v = hi + $urandom_range(1, 1 << 20);
      3:       v = longint'(rand_word());
      default: v = (hi > lo) ? lo + ({$urandom, $urandom} % (hi - lo + 1)) : lo;
    endcase
    if (v > 64'sh7fff_ffff) v = 64'sh7fff_ffff;
    if (v < -64'sh8000_0000) v = -64'sh8000_0000;
    return v[31:0];
  endfunction

  initial begin
    int i, phase, n, r;
    logic [4:0] xs [7];
    logic [4:0] ys [7];
    xs = '{5'd16, 5'd2, 5'd2, 5'd16, 5'd0, 5'd31, 5'd7};
    ys = '{5'd16, 5'd2, 5'd16, 5'd2, 5'd1, 5'd20, 5'd11};
    in_ch.valid <= 1'b0;
    in_ch.action <= bti_pkg::ACT_LOAD_X;
    in_ch.entry_index <= '0;
    in_ch.entry_value <= '0;
    in_ch.query_x <= '0;
    in_ch.query_y <= '0;
    cfg_we <= 1'b0;
    cfg_index <= bti_pkg::REG_X_COUNT;
    cfg_data <= '0;
    nx_use = 16;
    ny_use = 16;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    quiet = 1'b1;
    for (i = 0; i < 16; i++) load(bti_pkg::ACT_LOAD_X, 8'(i), i << 16);
    for (i = 0; i < 16; i++) load(bti_pkg::ACT_LOAD_Y, 8'(i), (2 * i) << 16);
    for (i = 0; i < 256; i++) load(bti_pkg::ACT_LOAD_G, 8'(i), rand_word());
    quiet = 1'b0;

    query(0, 0);
    query(15 << 16, 30 << 16);
    query(32'sh0003_8000, 32'sh0005_4000);
    query(-32'sh0001_0000, 32'sh0002_0000);
    query(32'sh0014_0000, 32'sh0040_0000);
    query(32'sh8000_0000, 32'sh8000_0000);
    query(32'sh7fff_ffff, 32'sh7fff_ffff);
    load(bti_pkg::ACT_LOAD_X, 8'd200, 32'sh0000_0000);
    load(bti_pkg::ACT_LOAD_G, 8'd255, 32'sh7fff_ffff);
    load(bti_pkg::ACT_LOAD_G, 8'd254, 32'sh8000_0000);
    load(bti_pkg::ACT_LOAD_G, 8'd0, 32'sh7fff_ffff);
    load(bti_pkg::ACT_LOAD_G, 8'd1, 32'sh7fff_ffff);
    load(bti_pkg::ACT_LOAD_G, 8'd16, 32'sh7fff_ffff);
    load(bti_pkg::ACT_LOAD_G, 8'd17, 32'sh7fff_ffff);
    query(32'sh0000_8000, 32'sh0000_8000);
    query(-32'sh0100_0000, -32'sh0100_0000);
    query(32'sh7fff_ffff, 32'sh0040_0000);
    load(bti_pkg::ACT_LOAD_X, 8'd1, 32'sh0000_0000);
    query(32'sh0000_0000, 32'sh0001_0000);
    query(32'sh0000_8000, 32'sh0000_8000);
    load(bti_pkg::ACT_LOAD_X, 8'd1, 32'sh0001_0000);
    query(32'sh0001_0000, 32'sh0002_0000);

    for (phase = 0; phase < 7; phase++) begin
      wait_idle();
      write_counts(xs[phase], ys[phase]);
      quiet = (phase == 3);
      load_axis(bti_pkg::ACT_LOAD_X);
      load_axis(bti_pkg::ACT_LOAD_Y);
      for (i = 0; i < 30; i++) load(bti_pkg::ACT_LOAD_G, 8'($urandom), rand_word());
      n = 0;
      while (n < 100) begin
        r = $urandom_range(0, 9);
        if (r < 7) begin
          query(pick_coord(x_tab, nx_use), pick_coord(y_tab, ny_use));
          n++;
        end else if (r < 9) load(bti_pkg::ACT_LOAD_G, 8'($urandom), rand_word());
        else load(2'($urandom_range(0, 1)), 8'($urandom), rand_word());
      end
    end

    wait_idle();
    if (errors == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

### bilinear_table_interpolator.f
+incdir+design
design/bti_pkg.sv
design/bti_if.sv
design/bti_ctrl.sv
design/bti_datapath.sv
design/bilinear_table_interpolator.sv
design/bti_checker.sv
test/bti_scoreboard.sv
test/tb_bilinear_table_interpolator.sv
